@@ sv/ukd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ukd_pkg
// Shared widths, constants and handshake structs for the ultrasonic
// distance filter: fixed-point formats, register indexes, divider control.
// ----------------------------------------------------------------------------
package ukd_pkg;

  localparam int RANGE_W   = 19;
  localparam int VAR_W     = 24;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;

  localparam int DIV_W     = 25;
  localparam int QUOT_W    = 17;
  localparam int DIV_CNT_W = 5;

  localparam int MUL_A_W   = 24;
  localparam int MUL_B_W   = 17;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam logic [RANGE_W-1:0] RANGE_MAX = {RANGE_W{1'b1}};
  localparam logic [VAR_W-1:0]   VAR_MAX   = {VAR_W{1'b1}};
  localparam logic [GAIN_W-1:0]  GAIN_MAX  = {GAIN_W{1'b1}};

  localparam logic [MUL_B_W-1:0] ONE_Q16   = 17'h10000;
  localparam logic [PROD_W:0]    HALF_Q16  = 42'd32768;

  // range = floor((us * 128 + 14) / 29), by reciprocal ceil(2^29 / 29)
  localparam logic [6:0]         ECHO_LOW     = 7'd14;
  localparam int                 ECHO_RECIP_W = 25;
  localparam int                 ECHO_PROD_W  = MUL_A_W + ECHO_RECIP_W;
  localparam logic [ECHO_RECIP_W-1:0] ECHO_RECIP = 25'd18512791;
  localparam int                 ECHO_SHIFT   = 29;
  localparam logic [31:0]        RANGE_SAT    = 32'd15204352;

  localparam logic [DIV_CNT_W-1:0] K_STEPS = 5'd17;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VARIANCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_THRESHOLD = 3'd4;

  localparam logic [VAR_W-1:0]   RST_PROCESS_NOISE      = 24'd65536;
  localparam logic [VAR_W-1:0]   RST_MEASUREMENT_NOISE  = 24'd65536;
  localparam logic [VAR_W-1:0]   RST_INITIAL_VARIANCE   = 24'd65536;
  localparam logic [RANGE_W-1:0] RST_INITIAL_ESTIMATE   = 19'd0;
  localparam logic [RANGE_W-1:0] RST_OBSTACLE_THRESHOLD = 19'd3840;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     rem0;
    logic [QUOT_W-1:0]    low;
    logic [DIV_W-1:0]     divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ sv/ukd_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ukd_if
// Valid/ready channels of the distance filter: echo pulse in, filtered
// distance and obstacle flags out.
// ----------------------------------------------------------------------------
interface ukd_in_if #(
  parameter int PULSE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PULSE_BITS-1:0] pulse_width_us;

  modport source (output valid, output pulse_width_us, input ready);
  modport sink   (input valid, input pulse_width_us, output ready);
endinterface

interface ukd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ukd_pkg::RANGE_W-1:0]  distance_estimate;
  logic                         obstacle_detected;
  logic                         obstacle_onset;

  modport source (output valid, output distance_estimate, output obstacle_detected,
                  output obstacle_onset, input ready);
  modport sink   (input valid, input distance_estimate, input obstacle_detected,
                  input obstacle_onset, output ready);
endinterface
`default_nettype wire

@@ sv/ukd_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ukd_div
// Restoring divider, one quotient bit per cycle. The caller supplies the
// upper part of the dividend as the starting remainder (below the divisor)
// and the remaining low bits msb-aligned.
// ----------------------------------------------------------------------------
module ukd_div (
  input  wire               clk,
  input  wire               rst_n,
  input  ukd_pkg::div_req_t req,
  output ukd_pkg::div_rsp_t rsp
);

  logic [ukd_pkg::DIV_W-1:0]     rem_r;
  logic [ukd_pkg::DIV_W-1:0]     div_r;
  logic [ukd_pkg::QUOT_W-1:0]    sh_r;
  logic [ukd_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;

  logic [ukd_pkg::DIV_W:0]   trial;
  logic                      ge;
  logic [ukd_pkg::DIV_W:0]   diff;
  logic [ukd_pkg::DIV_W-1:0] rem_nxt;

  assign trial   = {rem_r, sh_r[ukd_pkg::QUOT_W-1]};
  assign ge      = trial >= {1'b0, div_r};
  assign diff    = trial - {1'b0, div_r};
  assign rem_nxt = ge ? diff[ukd_pkg::DIV_W-1:0] : trial[ukd_pkg::DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem0;
      div_r <= req.divisor;
      sh_r  <= req.low;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[ukd_pkg::QUOT_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = sh_r;

endmodule
`default_nettype wire

@@ sv/ukd_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ukd_mul
// Shared unsigned multiplier with a registered product, used for the
// estimate and variance updates in turn.
// ----------------------------------------------------------------------------
module ukd_mul (
  input  wire                               clk,
  input  wire  [ukd_pkg::MUL_A_W-1:0]       a,
  input  wire  [ukd_pkg::MUL_B_W-1:0]       b,
  output logic [ukd_pkg::PROD_W-1:0]        prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule
`default_nettype wire

@@ sv/ultrasonic_kalman_distance_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_kalman_distance_unit
// Echo pulse width to range, then one scalar Kalman step per reading;
// returns filtered distance, obstacle flag and onset pulse.
// ----------------------------------------------------------------------------
//  channel   dir  transfer on          payload
//  in_ch     in   valid && ready       pulse_width_us
//  out_ch    out  valid && ready       distance_estimate, obstacle_detected,
//                                      obstacle_onset
//  cfg_*     in   cfg_we               cfg_index, cfg_wdata
//
//  the time from one input transfer to the next is set by the bit-serial
//  gain divider (17 steps plus start and finish), skipped when p + q (saturated)
//  plus r is zero, and by three passes through the shared multiplier
//  in_ch.ready is high only while idle; a finished result waits in the
//  output register while the next reading is taken
//  synchronous reset loads estimate 0 and variance 1.0
// ----------------------------------------------------------------------------
module ultrasonic_kalman_distance_unit #(
  parameter int PULSE_BITS = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  ukd_in_if.sink                          in_ch,
  ukd_out_if.source                       out_ch,
  input  wire                             cfg_we,
  input  wire  [ukd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [ukd_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int YW = PULSE_BITS + 7;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RANGE = 4'd1;
  localparam logic [3:0] S_GAIN  = 4'd3;
  localparam logic [3:0] S_KWAIT = 4'd4;
  localparam logic [3:0] S_M1    = 4'd5;
  localparam logic [3:0] S_M2    = 4'd6;
  localparam logic [3:0] S_M3    = 4'd7;
  localparam logic [3:0] S_M4    = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_r, state_nxt;

  logic [ukd_pkg::VAR_W-1:0]   q_r;
  logic [ukd_pkg::VAR_W-1:0]   r_r;
  logic [ukd_pkg::RANGE_W-1:0] thr_r;
  logic [ukd_pkg::RANGE_W-1:0] x_r;
  logic [ukd_pkg::VAR_W-1:0]   p_r;
  logic                        latched_r;

  logic [PULSE_BITS-1:0]       us_r;
  logic [ukd_pkg::RANGE_W-1:0] z_r;
  logic [ukd_pkg::VAR_W-1:0]   psat_r;
  logic [ukd_pkg::GAIN_W-1:0]  k_r;
  logic [ukd_pkg::PROD_W-1:0]  acc_r;

  logic [ukd_pkg::RANGE_W-1:0] dist_r;
  logic                        det_r;
  logic                        onset_r;
  logic                        out_valid_r;

  ukd_pkg::div_req_t div_req;
  ukd_pkg::div_rsp_t div_rsp;

  logic [ukd_pkg::MUL_A_W-1:0] mul_a;
  logic [ukd_pkg::MUL_B_W-1:0] mul_b;
  logic [ukd_pkg::PROD_W-1:0]  prod_r;

  logic                        in_xfer;
  logic                        out_free;
  logic [YW-1:0]               echo_y;
  logic [ukd_pkg::ECHO_PROD_W-1:0] echo_prod;
  logic                        zsat;
  logic [ukd_pkg::VAR_W:0]     pq_sum;
  logic [ukd_pkg::DIV_W-1:0]   den;
  logic [ukd_pkg::MUL_B_W-1:0] omk;
  logic [ukd_pkg::PROD_W:0]    x_sum;
  logic [ukd_pkg::PROD_W:0]    p_sum;
  logic [ukd_pkg::DIV_W:0]     x_full;
  logic [ukd_pkg::DIV_W-1:0]   p_full;
  logic                        det;

  assign in_ch.ready = rst_n && (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign echo_y    = {us_r, ukd_pkg::ECHO_LOW};
  assign zsat      = 32'(echo_y) >= ukd_pkg::RANGE_SAT;
  assign echo_prod = ukd_pkg::MUL_A_W'(echo_y) * ukd_pkg::ECHO_RECIP;
  assign pq_sum = {1'b0, p_r} + {1'b0, q_r};
  assign den    = {1'b0, psat_r} + {1'b0, r_r};
  assign omk    = ukd_pkg::ONE_Q16 - {1'b0, k_r};
  assign x_sum  = {1'b0, acc_r} + {1'b0, prod_r} + ukd_pkg::HALF_Q16;
  assign p_sum  = {1'b0, prod_r} + ukd_pkg::HALF_Q16;
  assign x_full = x_sum[ukd_pkg::PROD_W:16];
  assign p_full = p_sum[ukd_pkg::PROD_W-1:16];
  assign det    = x_r < thr_r;

  // divider request
  always_comb begin
    div_req = '0;
    if (state_r == S_GAIN) begin
      div_req.start   = den != '0;
      div_req.rem0    = {2'b00, psat_r[ukd_pkg::VAR_W-1:1]};
      div_req.low     = {psat_r[0], 16'h0000};
      div_req.divisor = den;
      div_req.steps   = ukd_pkg::K_STEPS;
    end
  end

  // multiplier operands
  always_comb begin
    case (state_r)
      S_M1: begin
        mul_a = {5'b00000, x_r};
        mul_b = omk;
      end
      S_M2: begin
        mul_a = {5'b00000, z_r};
        mul_b = {1'b0, k_r};
      end
      default: begin
        mul_a = psat_r;
        mul_b = omk;
      end
    endcase
  end

  ukd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ukd_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_RANGE;
      S_RANGE: state_nxt = S_GAIN;
      S_GAIN:  state_nxt = (den == '0) ? S_M1 : S_KWAIT;
      S_KWAIT: if (div_rsp.done) state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      q_r         <= ukd_pkg::RST_PROCESS_NOISE;
      r_r         <= ukd_pkg::RST_MEASUREMENT_NOISE;
      thr_r       <= ukd_pkg::RST_OBSTACLE_THRESHOLD;
      x_r         <= ukd_pkg::RST_INITIAL_ESTIMATE;
      p_r         <= ukd_pkg::RST_INITIAL_VARIANCE;
      latched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ukd_pkg::REG_PROCESS_NOISE:      q_r   <= cfg_wdata;
          ukd_pkg::REG_MEASUREMENT_NOISE:  r_r   <= cfg_wdata;
          ukd_pkg::REG_INITIAL_VARIANCE:   p_r   <= cfg_wdata;
          ukd_pkg::REG_INITIAL_ESTIMATE:   x_r   <= cfg_wdata[ukd_pkg::RANGE_W-1:0];
          ukd_pkg::REG_OBSTACLE_THRESHOLD: thr_r <= cfg_wdata[ukd_pkg::RANGE_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_M3) begin
        x_r <= (x_full > {7'd0, ukd_pkg::RANGE_MAX}) ? ukd_pkg::RANGE_MAX
                                                     : x_full[ukd_pkg::RANGE_W-1:0];
      end
      if (state_r == S_M4) begin
        p_r <= (p_full > {1'b0, ukd_pkg::VAR_MAX}) ? ukd_pkg::VAR_MAX
                                                   : p_full[ukd_pkg::VAR_W-1:0];
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
        latched_r   <= det;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) us_r <= in_ch.pulse_width_us;
    if (state_r == S_RANGE) begin
      psat_r <= pq_sum[ukd_pkg::VAR_W] ? ukd_pkg::VAR_MAX : pq_sum[ukd_pkg::VAR_W-1:0];
      z_r    <= zsat ? ukd_pkg::RANGE_MAX
                     : echo_prod[ukd_pkg::ECHO_SHIFT+ukd_pkg::RANGE_W-1:ukd_pkg::ECHO_SHIFT];
    end
    if (state_r == S_GAIN) k_r <= '0;
    if (state_r == S_KWAIT && div_rsp.done) begin
      k_r <= div_rsp.quot[ukd_pkg::GAIN_W] ? ukd_pkg::GAIN_MAX
                                           : div_rsp.quot[ukd_pkg::GAIN_W-1:0];
    end
    if (state_r == S_M2) acc_r <= prod_r;
    if (state_r == S_DONE && out_free) begin
      dist_r  <= x_r;
      det_r   <= det;
      onset_r <= det && !latched_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.distance_estimate = dist_r;
  assign out_ch.obstacle_detected = det_r;
  assign out_ch.obstacle_onset    = onset_r;

endmodule
`default_nettype wire

@@ sv/ukd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ukd_checker
// Port-level checks on the distance filter, bound to the top level.
// ----------------------------------------------------------------------------
module ukd_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_ready,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire [ukd_pkg::RANGE_W-1:0]       out_distance,
  input wire                              out_detected,
  input wire                              out_onset
);

  // result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_distance) && $stable(out_detected)
                                && $stable(out_onset))
    else $error("result changed while stalled");

  // one reading at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a reading is in flight");

  a_onset_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_onset |-> out_detected)
    else $error("onset without obstacle");

endmodule

bind ultrasonic_kalman_distance_unit ukd_checker u_ukd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_distance (out_ch.distance_estimate),
  .out_detected (out_ch.obstacle_detected),
  .out_onset    (out_ch.obstacle_onset)
);
`default_nettype wire

@@ verif/ultrasonic_kalman_distance_unit_test.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_kalman_distance_unit_test
// Checks the distance filter end to end: echo pulses go in over a valid/ready
// channel, and every filtered distance, obstacle flag and onset pulse is
// compared with a cycle-free scalar Kalman predictor kept in step with the
// register writes. Directed cases cover gain clamping, a zero denominator,
// variance saturation, register loading, the obstacle latch and unused
// register indexes. Random phases then vary noise, thresholds and start state.
// ----------------------------------------------------------------------------
module ultrasonic_kalman_distance_unit_test;

  localparam int PULSE_BITS     = 16;
  localparam int RESET_CYCLES   = 3;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_SHOWN      = 10;
  localparam int RANDOM_ITEMS   = 1330;
  localparam int STEADY_PHASE   = 4;
  localparam int STEADY_ITEMS   = 250;
  localparam int FRAC_BITS      = 8;

  localparam logic [63:0] CM_DIVISOR = 64'd58;
  localparam logic [63:0] CM_ROUND   = 64'd29;
  localparam logic [63:0] ONE_GAIN   = 64'd65536;
  localparam logic [63:0] HALF_LSB   = 64'd32768;

  localparam logic [PULSE_BITS-1:0] PULSE_MAX   = {PULSE_BITS{1'b1}};
  localparam logic [PULSE_BITS-1:0] PULSE_10CM  = 16'd580;
  localparam logic [PULSE_BITS-1:0] PULSE_5CM   = 16'd290;
  localparam logic [PULSE_BITS-1:0] PULSE_40CM  = 16'd2320;

  typedef struct packed {
    logic [ukd_pkg::RANGE_W-1:0] distance;
    logic                        detected;
    logic                        onset;
  } range_reading_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [ukd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ukd_pkg::CFG_W-1:0]     cfg_wdata;

  ukd_in_if #(.PULSE_BITS(PULSE_BITS)) pulse_ch ();
  ukd_out_if                           range_ch ();

  ultrasonic_kalman_distance_unit #(.PULSE_BITS(PULSE_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pulse_ch),
    .out_ch    (range_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state and register copies
  logic [ukd_pkg::VAR_W-1:0]   noise_q;
  logic [ukd_pkg::VAR_W-1:0]   noise_r;
  logic [ukd_pkg::VAR_W-1:0]   start_variance;
  logic [ukd_pkg::RANGE_W-1:0] start_estimate;
  logic [ukd_pkg::RANGE_W-1:0] obstacle_limit;
  logic [ukd_pkg::RANGE_W-1:0] filt_estimate;
  logic [ukd_pkg::VAR_W-1:0]   filt_variance;
  logic                        filt_latched;

  range_reading_t pending_ranges[$];
  range_reading_t oldest;
  int             error_count;
  int             quiet_cycles;
  int             stall_left;
  logic           no_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic range_reading_t predict_reading(input logic [PULSE_BITS-1:0] width);
    logic [63:0]    z;
    logic [63:0]    p;
    logic [63:0]    den;
    logic [63:0]    k;
    logic [63:0]    x;
    logic [63:0]    est;
    range_reading_t res;
    z = 64'(width);
    z = ((z << FRAC_BITS) + CM_ROUND) / CM_DIVISOR;
    if (z > 64'(ukd_pkg::RANGE_MAX)) z = 64'(ukd_pkg::RANGE_MAX);
    p = 64'(filt_variance);
    p = p + 64'(noise_q);
    if (p > 64'(ukd_pkg::VAR_MAX)) p = 64'(ukd_pkg::VAR_MAX);
    den = p + 64'(noise_r);
    if (den == '0) begin
      k = '0;
    end else begin
      k = (p << ukd_pkg::GAIN_W) / den;
      if (k > 64'(ukd_pkg::GAIN_MAX)) k = 64'(ukd_pkg::GAIN_MAX);
    end
    est = 64'(filt_estimate);
    x = (est * (ONE_GAIN - k) + z * k + HALF_LSB) >> ukd_pkg::GAIN_W;
    if (x > 64'(ukd_pkg::RANGE_MAX)) x = 64'(ukd_pkg::RANGE_MAX);
    p = (p * (ONE_GAIN - k) + HALF_LSB) >> ukd_pkg::GAIN_W;
    if (p > 64'(ukd_pkg::VAR_MAX)) p = 64'(ukd_pkg::VAR_MAX);
    filt_estimate = x[ukd_pkg::RANGE_W-1:0];
    filt_variance = p[ukd_pkg::VAR_W-1:0];
    res.distance = filt_estimate;
    res.detected = filt_estimate < obstacle_limit;
    res.onset    = res.detected && !filt_latched;
    filt_latched = res.detected;
    return res;
  endfunction

  function automatic void apply_register(input logic [ukd_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [ukd_pkg::CFG_W-1:0] data);
    case (idx)
      ukd_pkg::REG_PROCESS_NOISE:      noise_q = data[ukd_pkg::VAR_W-1:0];
      ukd_pkg::REG_MEASUREMENT_NOISE:  noise_r = data[ukd_pkg::VAR_W-1:0];
      ukd_pkg::REG_INITIAL_VARIANCE: begin
        start_variance = data[ukd_pkg::VAR_W-1:0];
        filt_variance  = start_variance;
      end
      ukd_pkg::REG_INITIAL_ESTIMATE: begin
        start_estimate = data[ukd_pkg::RANGE_W-1:0];
        filt_estimate  = start_estimate;
      end
      ukd_pkg::REG_OBSTACLE_THRESHOLD: obstacle_limit = data[ukd_pkg::RANGE_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic write_reg(input logic [ukd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ukd_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    apply_register(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_pulse(input logic [PULSE_BITS-1:0] width);
    int gap;
    gap = (!no_idle && $urandom_range(99) < 15) ? int'($urandom_range(1, 50)) : 0;
    @(negedge clk);
    if (gap != 0) begin
      pulse_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pulse_ch.pulse_width_us = width;
    pulse_ch.valid          = 1'b1;
    do @(posedge clk); while (!pulse_ch.ready);
    pending_ranges.push_back(predict_reading(width));
  endtask

  // block goes idle once its last result is taken
  task automatic wait_for_results();
    @(negedge clk);
    pulse_ch.valid = 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ukd_pkg::VAR_W-1:0] pick_variance();
    case ($urandom_range(9))
      0: return '0;
      1: return ukd_pkg::VAR_MAX;
      2: return ukd_pkg::VAR_W'($urandom_range(0, ukd_pkg::VAR_MAX));
      default: return ukd_pkg::VAR_W'($urandom_range(0, 24'h3FFFF));
    endcase
  endfunction

  function automatic logic [ukd_pkg::RANGE_W-1:0] pick_distance();
    case ($urandom_range(9))
      0: return '0;
      1: return ukd_pkg::RANGE_MAX;
      2: return ukd_pkg::RANGE_W'($urandom_range(0, ukd_pkg::RANGE_MAX));
      default: return ukd_pkg::RANGE_W'($urandom_range(0, 150 << FRAC_BITS));
    endcase
  endfunction

  function automatic logic [PULSE_BITS-1:0] pick_pulse();
    int near;
    case ($urandom_range(3))
      0: return PULSE_BITS'($urandom_range(0, PULSE_MAX));
      1: return PULSE_BITS'($urandom_range(0, 5800));
      2: begin
        near = ((int'(obstacle_limit) * int'(CM_DIVISOR)) >> FRAC_BITS)
               + int'($urandom_range(0, 100)) - 50;
        if (near < 0) near = 0;
        if (near > int'(PULSE_MAX)) near = int'(PULSE_MAX);
        return PULSE_BITS'(near);
      end
      default: return $urandom_range(1) ? PULSE_MAX : PULSE_BITS'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic randomize_registers(input bit write_all);
    logic [ukd_pkg::CFG_W-1:0]                  data;
    logic [ukd_pkg::CFG_W-ukd_pkg::RANGE_W-1:0] junk;
    for (int idx = ukd_pkg::REG_PROCESS_NOISE; idx <= ukd_pkg::REG_OBSTACLE_THRESHOLD;
         idx++) begin
      if (write_all || $urandom_range(1)) begin
        junk = (ukd_pkg::CFG_W-ukd_pkg::RANGE_W)'($urandom);
        if (idx == ukd_pkg::REG_INITIAL_ESTIMATE || idx == ukd_pkg::REG_OBSTACLE_THRESHOLD)
          data = {junk, pick_distance()};
        else
          data = pick_variance();
        write_reg(ukd_pkg::CFG_IDX_W'(idx), data);
      end
    end
  endtask

  task automatic test_reset_state();
    send_pulse('0);
    send_pulse(PULSE_MAX);
    send_pulse(16'd1);
    send_pulse(16'h8000);
    send_pulse(16'h5555);
    send_pulse(16'hAAAA);
  endtask

  task automatic test_gain_clamp();
    wait_for_results();
    write_reg(ukd_pkg::REG_MEASUREMENT_NOISE, '0);
    send_pulse(PULSE_10CM);
    send_pulse(PULSE_40CM);
  endtask

  task automatic test_zero_denominator();
    wait_for_results();
    write_reg(ukd_pkg::REG_PROCESS_NOISE, '0);
    write_reg(ukd_pkg::REG_INITIAL_VARIANCE, '0);
    write_reg(ukd_pkg::REG_INITIAL_ESTIMATE, 24'h012345);
    send_pulse(PULSE_MAX);
    send_pulse('0);
    send_pulse(PULSE_10CM);
  endtask

  task automatic test_variance_saturation();
    wait_for_results();
    write_reg(ukd_pkg::REG_PROCESS_NOISE, ukd_pkg::VAR_MAX);
    write_reg(ukd_pkg::REG_MEASUREMENT_NOISE, ukd_pkg::VAR_MAX);
    write_reg(ukd_pkg::REG_INITIAL_VARIANCE, ukd_pkg::VAR_MAX);
    write_reg(ukd_pkg::REG_INITIAL_ESTIMATE, {ukd_pkg::CFG_W{1'b1}});
    write_reg(ukd_pkg::REG_OBSTACLE_THRESHOLD, {ukd_pkg::CFG_W{1'b1}});
    send_pulse(PULSE_MAX);
    send_pulse('0);
  endtask

  // estimate tracks the reading closely, so flags follow the pulses
  task automatic test_obstacle_latch();
    wait_for_results();
    write_reg(ukd_pkg::REG_PROCESS_NOISE, ukd_pkg::RST_PROCESS_NOISE);
    write_reg(ukd_pkg::REG_MEASUREMENT_NOISE, '0);
    write_reg(ukd_pkg::REG_INITIAL_VARIANCE, ukd_pkg::RST_INITIAL_VARIANCE);
    write_reg(ukd_pkg::REG_INITIAL_ESTIMATE, 24'h040000);
    write_reg(ukd_pkg::REG_OBSTACLE_THRESHOLD,
              ukd_pkg::CFG_W'(ukd_pkg::RST_OBSTACLE_THRESHOLD));
    send_pulse(PULSE_40CM);
    send_pulse(PULSE_10CM);
    send_pulse(PULSE_10CM);
    send_pulse(PULSE_40CM);
    send_pulse(PULSE_10CM);
    send_pulse(PULSE_5CM);
  endtask

  task automatic test_unused_registers();
    wait_for_results();
    for (int idx = ukd_pkg::REG_OBSTACLE_THRESHOLD + 1; idx < (1 << ukd_pkg::CFG_IDX_W);
         idx++)
      write_reg(ukd_pkg::CFG_IDX_W'(idx),
                ukd_pkg::CFG_W'($urandom_range(0, {ukd_pkg::CFG_W{1'b1}})));
    write_reg(ukd_pkg::REG_OBSTACLE_THRESHOLD, '0);
    send_pulse(PULSE_10CM);
    send_pulse(PULSE_5CM);
  endtask

  task automatic test_random_filtering();
    int sent;
    int phase;
    int batch;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_for_results();
      randomize_registers(phase == 0);
      no_idle = (phase == STEADY_PHASE);
      batch   = no_idle ? STEADY_ITEMS : int'($urandom_range(20, 120));
      if (batch > RANDOM_ITEMS - sent) batch = RANDOM_ITEMS - sent;
      repeat (batch) begin
        if (!no_idle && $urandom_range(63) == 0) wait_for_results();
        send_pulse(pick_pulse());
        sent++;
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  // result side back-pressure: mostly short stalls, now and then a long one
  initial begin
    stall_left     = 0;
    range_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0)
        stall_left--;
      else if (!no_idle && $urandom_range(999) < 8)
        stall_left = ($urandom_range(7) == 0) ? int'($urandom_range(30, 90))
                                              : int'($urandom_range(1, 6));
      range_ch.ready = (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && range_ch.valid && range_ch.ready) begin
      if (pending_ranges.size() == 0) begin
        report_error("result transfer with nothing expected");
      end else begin
        oldest = pending_ranges.pop_front();
        if (range_ch.distance_estimate !== oldest.distance)
          report_error($sformatf("distance_estimate expected %0d, got %0d",
                                 oldest.distance, range_ch.distance_estimate));
        if (range_ch.obstacle_detected !== oldest.detected)
          report_error($sformatf("obstacle_detected expected %0b, got %0b",
                                 oldest.detected, range_ch.obstacle_detected));
        if (range_ch.obstacle_onset !== oldest.onset)
          report_error($sformatf("obstacle_onset expected %0b, got %0b",
                                 oldest.onset, range_ch.obstacle_onset));
      end
    end
  end

  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if ((pulse_ch.valid && pulse_ch.ready) || (range_ch.valid && range_ch.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = '0;
    cfg_wdata               = '0;
    pulse_ch.valid          = 1'b0;
    pulse_ch.pulse_width_us = '0;
    no_idle                 = 1'b0;
    error_count             = 0;
    noise_q                 = ukd_pkg::RST_PROCESS_NOISE;
    noise_r                 = ukd_pkg::RST_MEASUREMENT_NOISE;
    start_variance          = ukd_pkg::RST_INITIAL_VARIANCE;
    start_estimate          = ukd_pkg::RST_INITIAL_ESTIMATE;
    obstacle_limit          = ukd_pkg::RST_OBSTACLE_THRESHOLD;
    filt_estimate           = ukd_pkg::RST_INITIAL_ESTIMATE;
    filt_variance           = ukd_pkg::RST_INITIAL_VARIANCE;
    filt_latched            = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_gain_clamp();
    test_zero_denominator();
    test_variance_saturation();
    test_obstacle_latch();
    test_unused_registers();
    test_random_filtering();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_ranges.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_ranges.size()));
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ukd_pkg.sv
sv/ukd_if.sv
sv/ukd_div.sv
sv/ukd_mul.sv
sv/ultrasonic_kalman_distance_unit.sv
sv/ukd_checker.sv
verif/ultrasonic_kalman_distance_unit_test.sv
